// ----- src/sliding_window_anagram_match_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window anagram match unit
// Shared forms for same-cycle and next-cycle concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define SWAM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define SWAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/swam_pkg.sv -----
// ----------------------------------------------------------------------------
// swam_pkg
// Word types, codes and fixed sizes shared across the anagram match unit.
// ----------------------------------------------------------------------------
package swam_pkg;

   localparam int LETTER_W = 5;

   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_TEXT    = 1'b1;

   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 3;

   typedef struct packed {
      logic                req_type;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } swam_req_type;

   typedef struct packed {
      logic match_here;
      logic found_so_far;
      logic end_of_text;
   } swam_rsp_type;

   typedef struct packed {
      logic valid;
      logic clear;
      logic is_text;
      logic remove;
      logic full;
      logic last;
   } swam_op_type;

endpackage

// ----- src/swam_front.sv -----
// ----------------------------------------------------------------------------
// swam_front
// Search sequencing: pattern length, window fill, ring pointer and the ring
// of recent text letters. Issues at most one operation per accepted word.
// ----------------------------------------------------------------------------
module swam_front #(
   parameter int MAX_PATTERN = 256,
   parameter int ALPHABET    = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  swam_pkg::swam_req_type        req_data,
   output swam_pkg::swam_op_type         s1_op,
   output logic [$clog2(ALPHABET)-1:0]   s1_letter,
   output logic [$clog2(ALPHABET)-1:0]   s1_old_letter
);
   import swam_pkg::*;

   localparam int LetW = $clog2(ALPHABET);
   localparam int CntW = $clog2(MAX_PATTERN + 1);
   localparam int PtrW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [LetW-1:0] letter_map [2**LETTER_W];
   logic [LetW-1:0] letter;

   logic            open_ff, open_in;
   logic [CntW-1:0] plen_ff, plen_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [PtrW-1:0] wp_ff, wp_in;
   logic [CntW-1:0] plen_base;
   logic            start_new;

   logic [CntW:0]   wp_ext, plen_ext, oldest_sum;
   logic [PtrW-1:0] oldest;

   logic [LetW-1:0] ring [MAX_PATTERN];
   logic            ring_we;
   logic [LetW-1:0] ring_rd_ff;

   swam_op_type     op_ff, op_in;
   logic [LetW-1:0] letter_ff;

   for (genvar g = 0; g < 2**LETTER_W; g++) begin : g_map
      assign letter_map[g] = LetW'(g % ALPHABET);
   end

   assign letter = letter_map[req_data.letter];

   assign wp_ext     = (CntW+1)'(wp_ff);
   assign plen_ext   = (CntW+1)'(plen_ff);
   assign oldest_sum = (wp_ext >= plen_ext) ? wp_ext - plen_ext
                                            : wp_ext + (CntW+1)'(MAX_PATTERN) - plen_ext;
   assign oldest     = oldest_sum[PtrW-1:0];

   always_comb begin
      open_in   = open_ff;
      plen_in   = plen_ff;
      fill_in   = fill_ff;
      wp_in     = wp_ff;
      op_in     = '0;
      ring_we   = 1'b0;
      start_new = !open_ff || (fill_ff != '0);
      plen_base = start_new ? '0 : plen_ff;
      if (req_accept) begin
         if (req_data.req_type == REQ_PATTERN) begin
            if (start_new) begin
               open_in = 1'b1;
               fill_in = '0;
               wp_in   = '0;
               plen_in = '0;
            end
            if (plen_base < CntW'(MAX_PATTERN)) begin
               plen_in     = plen_base + CntW'(1);
               op_in.valid = 1'b1;
               op_in.clear = start_new;
            end
         end else if (open_ff) begin
            op_in.valid   = 1'b1;
            op_in.is_text = 1'b1;
            op_in.last    = req_data.last;
            ring_we       = 1'b1;
            wp_in         = (wp_ff == PtrW'(MAX_PATTERN - 1)) ? '0 : wp_ff + PtrW'(1);
            if (fill_ff < plen_ff) begin
               fill_in    = fill_ff + CntW'(1);
               op_in.full = ((fill_ff + CntW'(1)) == plen_ff);
            end else begin
               op_in.remove = 1'b1;
               op_in.full   = 1'b1;
            end
            if (req_data.last) begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         plen_ff <= '0;
         fill_ff <= '0;
         wp_ff   <= '0;
         op_ff   <= '0;
      end else begin
         open_ff <= open_in;
         plen_ff <= plen_in;
         fill_ff <= fill_in;
         wp_ff   <= wp_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter;
   end

   // read returns the entry before this cycle's write
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[wp_ff] <= letter;
      end
      ring_rd_ff <= ring[oldest];
   end

   assign s1_op         = op_ff;
   assign s1_letter     = letter_ff;
   assign s1_old_letter = ring_rd_ff;

endmodule

// ----- src/swam_count.sv -----
// ----------------------------------------------------------------------------
// swam_count
// Letter count memories with read-modify-write, forwarding of the previous
// write, per-entry valid bits, and the running unequal count and found flag.
// ----------------------------------------------------------------------------
module swam_count #(
   parameter int MAX_PATTERN = 256,
   parameter int ALPHABET    = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swam_pkg::swam_op_type         s1_op,
   input  logic [$clog2(ALPHABET)-1:0]   s1_letter,
   input  logic [$clog2(ALPHABET)-1:0]   s1_old_letter,
   output logic                          push,
   output swam_pkg::swam_rsp_type        push_data
);
   import swam_pkg::*;

   localparam int LetW = $clog2(ALPHABET);
   localparam int CntW = $clog2(MAX_PATTERN + 1);
   localparam int PaW  = 2 * CntW;
   localparam int UnqW = $clog2(ALPHABET + 1);

   // pattern count in the upper half, window adds in the lower half
   logic [PaW-1:0]  pa_mem [ALPHABET];
   // window removals
   logic [CntW-1:0] r_mem [ALPHABET];

   logic [PaW-1:0]  pa_rd_n_ff, pa_rd_o_ff;
   logic [CntW-1:0] r_rd_n_ff, r_rd_o_ff;

   swam_op_type     op_ff;
   logic [LetW-1:0] n_ff, o_ff;

   logic [ALPHABET-1:0] pa_vld_ff, pa_vld_in;
   logic [ALPHABET-1:0] r_vld_ff, r_vld_in;

   logic            fwd_pa_v_ff;
   logic [LetW-1:0] fwd_pa_addr_ff;
   logic [PaW-1:0]  fwd_pa_data_ff;
   logic            fwd_r_v_ff;
   logic [LetW-1:0] fwd_r_addr_ff;
   logic [CntW-1:0] fwd_r_data_ff;

   logic [UnqW-1:0] unq_ff, unq_in, unq_base;
   logic            found_ff, found_in, found_base;

   logic [PaW-1:0]  pa_n, pa_o;
   logic [CntW-1:0] r_n, r_o;
   logic [CntW-1:0] p_n, a_n, p_o, a_o, w_n, w_o;
   logic            rem_eff, same;
   logic            pa_we, r_we;
   logic [PaW-1:0]  pa_wdata;
   logic [CntW-1:0] r_wdata;
   logic            add_up, add_dn, rem_up, rem_dn;
   logic            match;

   always_comb begin
      pa_n = '0;
      pa_o = '0;
      r_n  = '0;
      r_o  = '0;
      if (!op_ff.clear) begin
         if (fwd_pa_v_ff && (fwd_pa_addr_ff == n_ff)) begin
            pa_n = fwd_pa_data_ff;
         end else if (pa_vld_ff[n_ff]) begin
            pa_n = pa_rd_n_ff;
         end
         if (fwd_pa_v_ff && (fwd_pa_addr_ff == o_ff)) begin
            pa_o = fwd_pa_data_ff;
         end else if (pa_vld_ff[o_ff]) begin
            pa_o = pa_rd_o_ff;
         end
         if (fwd_r_v_ff && (fwd_r_addr_ff == n_ff)) begin
            r_n = fwd_r_data_ff;
         end else if (r_vld_ff[n_ff]) begin
            r_n = r_rd_n_ff;
         end
         if (fwd_r_v_ff && (fwd_r_addr_ff == o_ff)) begin
            r_o = fwd_r_data_ff;
         end else if (r_vld_ff[o_ff]) begin
            r_o = r_rd_o_ff;
         end
      end
   end

   assign p_n = pa_n[PaW-1:CntW];
   assign a_n = pa_n[CntW-1:0];
   assign p_o = pa_o[PaW-1:CntW];
   assign a_o = pa_o[CntW-1:0];
   assign w_n = a_n - r_n;
   assign w_o = a_o - r_o;

   assign rem_eff = op_ff.is_text && op_ff.remove && (w_o != '0);
   assign same    = (n_ff == o_ff);

   always_comb begin
      pa_we    = 1'b0;
      r_we     = 1'b0;
      pa_wdata = pa_n;
      r_wdata  = r_o + CntW'(1);
      add_up   = 1'b0;
      add_dn   = 1'b0;
      rem_up   = 1'b0;
      rem_dn   = 1'b0;
      if (op_ff.valid) begin
         pa_we = 1'b1;
         if (!op_ff.is_text) begin
            pa_wdata = {p_n + CntW'(1), a_n};
            add_up   = (p_n == w_n);
            add_dn   = ((p_n + CntW'(1)) == w_n);
         end else begin
            pa_wdata = {p_n, a_n + CntW'(1)};
            r_we     = rem_eff;
            // drop and add of the same letter leave its count unchanged
            if (!(rem_eff && same)) begin
               if (rem_eff) begin
                  rem_up = (p_o == w_o);
                  rem_dn = (p_o == (w_o - CntW'(1)));
               end
               add_up = (p_n == w_n);
               add_dn = (p_n == (w_n + CntW'(1)));
            end
         end
      end
   end

   assign unq_base   = op_ff.clear ? '0 : unq_ff;
   assign found_base = op_ff.clear ? 1'b0 : found_ff;
   assign unq_in     = unq_base + UnqW'(add_up) + UnqW'(rem_up)
                     - UnqW'(add_dn) - UnqW'(rem_dn);
   assign match      = op_ff.valid && op_ff.is_text && op_ff.full && (unq_in == '0);
   assign found_in   = found_base || match;

   always_comb begin
      pa_vld_in = op_ff.clear ? '0 : pa_vld_ff;
      r_vld_in  = op_ff.clear ? '0 : r_vld_ff;
      if (pa_we) begin
         pa_vld_in[n_ff] = 1'b1;
      end
      if (r_we) begin
         r_vld_in[o_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pa_we) begin
         pa_mem[n_ff] <= pa_wdata;
      end
      pa_rd_n_ff <= pa_mem[s1_letter];
      pa_rd_o_ff <= pa_mem[s1_old_letter];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         r_mem[o_ff] <= r_wdata;
      end
      r_rd_n_ff <= r_mem[s1_letter];
      r_rd_o_ff <= r_mem[s1_old_letter];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= '0;
         pa_vld_ff   <= '0;
         r_vld_ff    <= '0;
         fwd_pa_v_ff <= 1'b0;
         fwd_r_v_ff  <= 1'b0;
         unq_ff      <= '0;
         found_ff    <= 1'b0;
      end else begin
         op_ff       <= s1_op;
         pa_vld_ff   <= pa_vld_in;
         r_vld_ff    <= r_vld_in;
         fwd_pa_v_ff <= pa_we;
         fwd_r_v_ff  <= r_we;
         unq_ff      <= unq_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= s1_letter;
      o_ff           <= s1_old_letter;
      fwd_pa_addr_ff <= n_ff;
      fwd_pa_data_ff <= pa_wdata;
      fwd_r_addr_ff  <= o_ff;
      fwd_r_data_ff  <= r_wdata;
   end

   assign push                   = op_ff.valid && op_ff.is_text;
   assign push_data.match_here   = match;
   assign push_data.found_so_far = found_in;
   assign push_data.end_of_text  = op_ff.last;

endmodule

// ----- src/swam_outq.sv -----
// ----------------------------------------------------------------------------
// swam_outq
// Result queue with room check that counts words still in the pipeline.
// ----------------------------------------------------------------------------
module swam_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swam_pkg::swam_rsp_type push_data,
   input  logic [1:0]             inflight,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output swam_pkg::swam_rsp_type rsp_data,
   output logic                   room
);
   import swam_pkg::*;

   swam_rsp_type          q [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] head_ff, head_in;
   logic [OUTQ_PTR_W-1:0] tail_ff, tail_in;
   logic [OUTQ_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff + OUTQ_CNT_W'(inflight)) < OUTQ_CNT_W'(OUTQ_DEPTH);

   always_comb begin
      head_in  = pop ? head_ff + OUTQ_PTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + OUTQ_PTR_W'(1) : tail_ff;
      count_in = count_ff + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q[tail_ff] <= push_data;
      end
   end

endmodule

// ----- src/sliding_window_anagram_match_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_anagram_match_unit
// Send the pattern one letter per word, then the text one letter per word.
// Pattern words give no result; every text word in an open search gives one
// result word saying whether the last pattern-length text letters are a
// permutation of the pattern, plus a sticky found flag and an end-of-text
// mark. A pattern word after text starts a new search. The unit takes one
// word per cycle, pattern or text, while req_stall is low, and each result
// is registered in the front stage, the count stage and the queue. The front
// stage reads the ring memory for the letter leaving the window, then the
// count stage does the read-modify-write of the two count memories, each with
// a registered read; back-to-back words to the same letter are forwarded.
// Results pass through a four-word queue; req_stall rises when the queue and
// the words in flight would fill it. A new search clears the count tables
// through per-letter valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_anagram_match_unit #(
   parameter int MAX_PATTERN = 256,
   parameter int ALPHABET    = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swam_pkg::swam_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swam_pkg::swam_rsp_type rsp_data
);
   import swam_pkg::*;

   localparam int LetW = $clog2(ALPHABET);

   logic            req_accept;
   swam_op_type     s1_op;
   logic [LetW-1:0] s1_letter, s1_old_letter;
   logic            push;
   swam_rsp_type    push_data;
   logic [1:0]      inflight;
   logic            room;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = !room;
   assign inflight   = 2'(s1_op.valid && s1_op.is_text) + 2'(push);

   swam_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_data      (req_data),
      .s1_op         (s1_op),
      .s1_letter     (s1_letter),
      .s1_old_letter (s1_old_letter)
   );

   swam_count #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_count (
      .clock         (clock),
      .reset         (reset),
      .s1_op         (s1_op),
      .s1_letter     (s1_letter),
      .s1_old_letter (s1_old_letter),
      .push          (push),
      .push_data     (push_data)
   );

   swam_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .inflight  (inflight),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .room      (room)
   );

endmodule

// ----- src/swam_checker.sv -----
// ----------------------------------------------------------------------------
// swam_checker
// Port-level checks on the anagram match unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_anagram_match_unit_assert.svh"

module swam_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input swam_pkg::swam_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input swam_pkg::swam_rsp_type rsp_data
);
   import swam_pkg::*;

   `SWAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result word changed")

   `SWAM_ASSERT_SAME(a_match_found, clock, reset, rsp_valid && rsp_data.match_here,
      rsp_data.found_so_far, "match without found flag")

   `SWAM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset,
      !rsp_valid && !req_stall, "not idle after reset")

   `SWAM_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall && (req_data.req_type == REQ_TEXT), 3),
      "result word without a text word three cycles before")

endmodule

bind sliding_window_anagram_match_unit swam_checker u_swam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/sliding_window_anagram_match_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for sliding_window_anagram_match_unit
// Sends patterns and texts as one letter per word, tracks letter counts of the
// pattern and of the sliding text window in a scoreboard, and checks every
// result word field by field against the predicted permutation verdict.
// ----------------------------------------------------------------------------
import swam_pkg::*;

class window_match_board;
   localparam int ALPHABET    = 26;
   localparam int MAX_PATTERN = 256;

   bit [8:0] pattern_tally [ALPHABET];
   bit [8:0] window_tally [ALPHABET];
   bit [4:0] recent [MAX_PATTERN];
   bit [7:0] ring_head;
   bit [8:0] pattern_len;
   bit [8:0] window_len;
   bit [4:0] mismatched;
   bit       seen_match;
   bit       search_live;
   swam_rsp_type verdicts_due [$];
   int       errors;

   function new();
      restart();
      search_live = 1'b0;
      errors = 0;
   endfunction

   function void restart();
      foreach (pattern_tally[i]) begin
         pattern_tally[i] = '0;
         window_tally[i] = '0;
      end
      ring_head = '0;
      pattern_len = '0;
      window_len = '0;
      mismatched = '0;
      seen_match = 1'b0;
   endfunction

   function void shift_tally(bit in_window, int idx, bit up);
      bit was_diff;
      bit is_diff;
      was_diff = pattern_tally[idx] != window_tally[idx];
      if (in_window) begin
         if (up) window_tally[idx]++;
         else if (window_tally[idx] != 0) window_tally[idx]--;
      end else begin
         if (up) pattern_tally[idx]++;
         else if (pattern_tally[idx] != 0) pattern_tally[idx]--;
      end
      is_diff = pattern_tally[idx] != window_tally[idx];
      if (was_diff && !is_diff) mismatched--;
      else if (!was_diff && is_diff) mismatched++;
   endfunction

   function void take_letter(swam_req_type w);
      int idx;
      int oldest;
      bit hit;
      swam_rsp_type v;
      idx = int'(w.letter) % ALPHABET;
      if (w.req_type == REQ_PATTERN) begin
         if (!search_live || window_len != 0) begin
            restart();
            search_live = 1'b1;
         end
         if (pattern_len < MAX_PATTERN) begin
            pattern_len++;
            shift_tally(1'b0, idx, 1'b1);
         end
         return;
      end
      if (!search_live) return;
      if (window_len < pattern_len) begin
         window_len++;
      end else begin
         oldest = (int'(ring_head) + MAX_PATTERN - int'(pattern_len)) % MAX_PATTERN;
         shift_tally(1'b1, int'(recent[oldest]), 1'b0);
      end
      shift_tally(1'b1, idx, 1'b1);
      recent[ring_head] = 5'(idx);
      ring_head++;
      hit = (window_len == pattern_len) && (mismatched == 0);
      if (hit) seen_match = 1'b1;
      v.match_here = hit;
      v.found_so_far = seen_match;
      v.end_of_text = w.last;
      verdicts_due.push_back(v);
      if (w.last) search_live = 1'b0;
   endfunction

   function void check_verdict(swam_rsp_type r);
      swam_rsp_type e;
      if (verdicts_due.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual %b", $time, r);
         errors++;
         return;
      end
      e = verdicts_due.pop_front();
      if (r.match_here !== e.match_here) begin
         $display("%0t: match_here: expected %b, actual %b", $time, e.match_here,
                  r.match_here);
         errors++;
      end
      if (r.found_so_far !== e.found_so_far) begin
         $display("%0t: found_so_far: expected %b, actual %b", $time, e.found_so_far,
                  r.found_so_far);
         errors++;
      end
      if (r.end_of_text !== e.end_of_text) begin
         $display("%0t: end_of_text: expected %b, actual %b", $time, e.end_of_text,
                  r.end_of_text);
         errors++;
      end
   endfunction
endclass

module sliding_window_anagram_match_unit_tb;
   localparam int STUCK_LIMIT = 2000;
   localparam int WORD_TARGET = 1350;
   localparam int CALM_AFTER  = 1150;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   swam_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   swam_rsp_type rsp_data;

   window_match_board board = new();
   bit calm = 1'b0;
   int sender_gap_pct = 0;
   int stuck_cycles = 0;

   sliding_window_anagram_match_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      bit took;
      took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.take_letter(req_data);
            took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_verdict(rsp_data);
            took = 1'b1;
         end
         if (took) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned spell_letter(int unsigned l);
      if (l < 6 && $urandom_range(0, 2) == 0) return l + 26;
      return l;
   endfunction

   task automatic send_word(input logic kind, input int unsigned l, input logic fin);
      swam_req_type w;
      if (!calm && sender_gap_pct != 0 && $urandom_range(1, 100) <= sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      w.req_type = kind;
      w.letter = 5'(l);
      w.last = fin;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed_words();
      send_word(REQ_TEXT, 0, 1'b0);
      send_word(REQ_TEXT, 31, 1'b1);
      send_word(REQ_PATTERN, 25, 1'b1);
      send_word(REQ_PATTERN, 31, 1'b0);
      send_word(REQ_TEXT, 5, 1'b0);
      send_word(REQ_TEXT, 25, 1'b0);
      send_word(REQ_TEXT, 30, 1'b0);
      send_word(REQ_TEXT, 26, 1'b1);
      send_word(REQ_TEXT, 7, 1'b0);
      send_word(REQ_PATTERN, 2, 1'b0);
      send_word(REQ_TEXT, 28, 1'b0);
      send_word(REQ_TEXT, 2, 1'b0);
      send_word(REQ_PATTERN, 0, 1'b0);
      send_word(REQ_PATTERN, 27, 1'b0);
      send_word(REQ_PATTERN, 0, 1'b0);
      send_word(REQ_TEXT, 1, 1'b0);
      send_word(REQ_TEXT, 0, 1'b0);
      send_word(REQ_TEXT, 0, 1'b0);
      send_word(REQ_TEXT, 16, 1'b0);
      send_word(REQ_TEXT, 0, 1'b1);
      send_word(REQ_PATTERN, 31, 1'b1);
      send_word(REQ_TEXT, 5, 1'b1);
   endtask

   task automatic run_search(inout int budget, input bit closed);
      int plen;
      int tlen;
      int span;
      int base;
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      span = $urandom_range(1, 5);
      base = $urandom_range(0, 26 - span);
      for (int i = 0; i < plen; i++)
         send_word(REQ_PATTERN, spell_letter(base + $urandom_range(0, span - 1)),
                   1'($urandom_range(0, 1)));
      tlen = $urandom_range(1, plen + 24);
      for (int i = 0; i < tlen; i++)
         send_word(REQ_TEXT, spell_letter(base + $urandom_range(0, span - 1)),
                   closed && (i == tlen - 1));
      budget += plen + tlen;
   endtask

   // pattern runs past the count limit; text repeats the counted part so the
   // window wraps the ring and keeps matching
   task automatic run_long_search(inout int budget);
      bit [4:0] pat [258];
      for (int i = 0; i < 258; i++) begin
         pat[i] = 5'($urandom_range(0, 25));
         send_word(REQ_PATTERN, pat[i], 1'b0);
      end
      for (int i = 0; i < 260; i++)
         send_word(REQ_TEXT, pat[i % 256], i == 259);
      budget += 518;
   endtask

   initial begin
      int budget;
      int pick;
      bit long_done;
      budget = 0;
      long_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed_words();
      drain_results();
      while (budget < WORD_TARGET) begin
         calm = budget > CALM_AFTER;
         sender_gap_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         pick = $urandom_range(0, 99);
         if (!long_done && budget > 300) begin
            run_long_search(budget);
            long_done = 1'b1;
         end else if (pick < 75) begin
            run_search(budget, 1'b1);
         end else if (pick < 85) begin
            run_search(budget, 1'b0);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 3))
               send_word(REQ_TEXT, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 6))
               send_word(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                         1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 39) == 0) drain_results();
      end
      drain_results();
      repeat (16) @(posedge clock);
      if (board.verdicts_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, board.verdicts_due.size());
         board.errors++;
      end
      if (board.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
